### hdl/bttd_pkg.sv
`default_nettype none

package bttd_pkg;

  // width of the value field on the port and the part of it that is converted
  localparam int VALUE_FIELD_W = 64;
  localparam int VALUE_WIDTH   = 64;

  // divider produces this many quotient bits per cycle while busy
  localparam int DIGIT_BITS = 8;
  localparam int CHUNKS     = (VALUE_WIDTH + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int SHIFT_W    = CHUNKS * DIGIT_BITS;
  localparam int CHUNK_CW   = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

  localparam int TRIT_DEPTH = 41;
  localparam int TRIT_AW    = $clog2(TRIT_DEPTH);
  localparam int CNT_W      = $clog2(TRIT_DEPTH + 1);

  localparam int CHAR_W = 6;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 6'd48;
  localparam logic [2:0]        RADIX     = 3'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_FETCH,
    S_LOAD,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic again;
  } div_ctrl_t;

  typedef struct packed {
    logic       done;
    logic [1:0] rem;
    logic       q_zero;
  } div_stat_t;

endpackage

`default_nettype wire

### hdl/bttd_if.sv
`default_nettype none

interface bttd_value_if;
  import bttd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [VALUE_FIELD_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface bttd_trit_if;
  import bttd_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] trit_char;
  logic              digit_valid;
  logic              last;

  modport source (output valid, output trit_char, output digit_valid, output last, input ready);
  modport sink   (input valid, input trit_char, input digit_valid, input last, output ready);
endinterface

`default_nettype wire

### hdl/bttd_div3.sv
`default_nettype none

module bttd_div3 (
  input  logic                         clk,
  input  logic                         rst,
  input  bttd_pkg::div_ctrl_t          ctrl,
  input  logic [bttd_pkg::SHIFT_W-1:0] operand,
  output bttd_pkg::div_stat_t          stat
);
  import bttd_pkg::*;

  logic [SHIFT_W-1:0]    quot;
  logic [1:0]            rem;
  logic                  nz;
  logic                  busy;
  logic                  done;
  logic [CHUNK_CW-1:0]   cnt;
  logic [DIGIT_BITS-1:0] q_chunk;
  logic [1:0]            rem_next;

  // long division of the top chunk, msb first, remainder stays below three
  always_comb begin : chunk_step
    logic [2:0] t;
    logic [1:0] r;
    r       = rem;
    q_chunk = '0;
    for (int i = DIGIT_BITS - 1; i >= 0; i--) begin
      t = {r, quot[SHIFT_W-DIGIT_BITS+i]};
      if (t >= RADIX) begin
        q_chunk[i] = 1'b1;
        t          = t - RADIX;
      end
      r = t[1:0];
    end
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.load || ctrl.again) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CHUNK_CW'(CHUNKS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient bits enter at the bottom as the dividend leaves at the top
  always_ff @(posedge clk) begin
    if (ctrl.load || ctrl.again) begin
      rem <= 2'd0;
      nz  <= 1'b0;
      if (ctrl.load) begin
        quot <= operand;
      end
    end else if (busy) begin
      quot <= (quot << DIGIT_BITS) | SHIFT_W'(q_chunk);
      rem  <= rem_next;
      nz   <= nz | (|q_chunk);
    end
  end

  assign stat.done   = done;
  assign stat.rem    = rem;
  assign stat.q_zero = ~nz;

endmodule

`default_nettype wire

### hdl/binary_to_ternary_digits_unit.sv
// a zero value gives its single beat in the cycle after acceptance
// the serial divider works out each ternary digit over all CHUNKS chunks of the value (8 value bits a cycle)
// n digits: the first beat follows once all n digits are divided and read back via S_FETCH and S_LOAD
// one value at a time, at most 41 digits; a new value is accepted only once the final beat is taken
// rst is synchronous and active high: returns to idle, digit count cleared, digit store not cleared
`default_nettype none

module binary_to_ternary_digits_unit (
  input  logic         clk,
  input  logic         rst,
  bttd_value_if.sink   din,
  bttd_trit_if.source  dout
);
  import bttd_pkg::*;

  state_t             state;
  state_t             state_next;
  logic [CNT_W-1:0]   digit_count;
  logic [TRIT_AW-1:0] ptr;
  logic [TRIT_AW-1:0] rd_addr;
  logic [1:0]         digit_store [TRIT_DEPTH];
  logic [1:0]         rd_data;
  logic [CHAR_W-1:0]  trit_q;
  logic               dvalid_q;
  logic               last_q;
  div_ctrl_t          div_ctrl;
  div_stat_t          div_stat;
  logic [SHIFT_W-1:0] operand;
  logic               value_zero;
  logic               store_we;
  logic               final_digit;
  logic               in_fire;
  logic               out_fire;

  assign operand     = SHIFT_W'(din.value[VALUE_WIDTH-1:0]);
  assign value_zero  = ~|din.value[VALUE_WIDTH-1:0];
  assign final_digit = div_stat.q_zero || (digit_count == CNT_W'(TRIT_DEPTH - 1));
  assign in_fire     = din.valid && din.ready;
  assign out_fire    = dout.valid && dout.ready;

  bttd_div3 u_div (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (div_ctrl),
    .operand (operand),
    .stat    (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    din.ready  = 1'b0;
    div_ctrl   = '0;
    store_we   = 1'b0;
    unique case (state)
      S_IDLE: begin
        din.ready = 1'b1;
        if (din.valid) begin
          if (value_zero) begin
            state_next = S_OUT;
          end else begin
            div_ctrl.load = 1'b1;
            state_next    = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          store_we = 1'b1;
          if (final_digit) begin
            state_next = S_FETCH;
          end else begin
            div_ctrl.again = 1'b1;
          end
        end
      end
      S_FETCH: state_next = S_LOAD;
      S_LOAD:  state_next = S_OUT;
      S_OUT: begin
        if (dout.ready) begin
          state_next = last_q ? S_IDLE : S_LOAD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // while a beat waits, look one digit ahead so the next load finds it
  always_comb begin
    if (state == S_OUT && ptr != '0) begin
      rd_addr = ptr - 1'b1;
    end else begin
      rd_addr = ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= '0;
    end else if (in_fire) begin
      digit_count <= '0;
    end else if (store_we) begin
      digit_count <= digit_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we && final_digit) begin
      ptr <= digit_count[TRIT_AW-1:0];
    end else if (out_fire && !last_q) begin
      ptr <= ptr - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      digit_store[digit_count[TRIT_AW-1:0]] <= div_stat.rem;
    end
    rd_data <= digit_store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (in_fire && value_zero) begin
      trit_q   <= CHAR_ZERO;
      dvalid_q <= 1'b0;
      last_q   <= 1'b1;
    end else if (state == S_LOAD) begin
      trit_q   <= CHAR_ZERO + CHAR_W'(rd_data);
      dvalid_q <= 1'b1;
      last_q   <= (ptr == '0);
    end
  end

  assign dout.valid       = (state == S_OUT);
  assign dout.trit_char   = trit_q;
  assign dout.digit_valid = dvalid_q;
  assign dout.last        = last_q;

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    dout.valid |-> !din.ready)
    else $error("input taken while a beat is pending");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    digit_count <= CNT_W'(TRIT_DEPTH))
    else $error("digit count past store depth");

  a_zero_last: assert property (@(posedge clk) disable iff (rst)
    (dout.valid && !dout.digit_valid) |-> dout.last)
    else $error("empty beat not marked last");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    (dout.valid && dout.digit_valid) |->
      (dout.trit_char == CHAR_ZERO || dout.trit_char == CHAR_ZERO + 6'd1 ||
       dout.trit_char == CHAR_ZERO + 6'd2))
    else $error("digit character out of range");

  a_return_idle: assert property (@(posedge clk) disable iff (rst)
    (dout.valid && dout.ready && dout.last) |=> din.ready)
    else $error("not ready after final beat");

endmodule

`default_nettype wire
